// File: hw/rtl/sha256bs_pkg.sv
package sha256bs_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int WIN_WORDS   = 16;
  localparam int ROUNDS      = 64;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// File: hw/rtl/sha256_byte_stream_hasher_core.sv
// sha-256 over a byte stream, one round per cycle through a single shared round unit
// a byte beat is taken while idle; the 64th byte of a block starts the 64 rounds, then the chain add
// end of message: one padding byte per cycle up to the block end, then rounds and chain add per
// final block (one or two), then the digest is handed over once the previous digest has fully
// drained, then 8 output beats; the digest drains from its own buffer, so the next
// message is taken meanwhile
// synchronous active-low reset: chain value = initial hash, fill and bit count = 0, idle
module sha256_byte_stream_hasher_core
  import sha256bs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // message_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word
  output logic [2:0]  out_tuser,  // word_index
  output logic        out_tlast   // last_word
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [1:0] AFT_IDLE = 2'd0;
  localparam logic [1:0] AFT_PAD  = 2'd1;
  localparam logic [1:0] AFT_DONE = 2'd2;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  after_r, after_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [63:0] bitcnt_r, bitcnt_nxt;
  logic        sent80_r, sent80_nxt;
  logic        len_ok_r, len_ok_nxt;
  logic        out_busy_r, out_busy_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [31:0] vars_r [8];
  logic [31:0] vars_nxt [8];
  logic [31:0] win_r [WIN_WORDS];
  logic [31:0] win_nxt [WIN_WORDS];
  logic [31:0] dig_r [8];
  logic [31:0] dig_nxt [8];

  logic        in_acc, out_acc;
  logic        ins_en;
  logic [7:0]  ins_byte, pad_byte, len_byte;
  logic [31:0] t1, t2, w_new;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_busy_r;
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = dig_r[out_idx_r];
  assign out_tuser  = out_idx_r;
  assign out_tlast  = (out_idx_r == 3'd7);

  // length bytes go out most significant first
  assign len_byte = 8'(bitcnt_r >> {3'd7 - fill_r[2:0], 3'b000});
  assign pad_byte = !sent80_r ? PAD_MARK :
                    (len_ok_r && fill_r >= LEN_START) ? len_byte : 8'h00;

  // shared round unit
  assign t1 = vars_r[7] + big_sig1(vars_r[4]) +
              ((vars_r[4] & vars_r[5]) ^ (~vars_r[4] & vars_r[6])) +
              K_TAB[rnd_r] + win_r[0];
  assign t2 = big_sig0(vars_r[0]) +
              ((vars_r[0] & vars_r[1]) ^ (vars_r[0] & vars_r[2]) ^ (vars_r[1] & vars_r[2]));
  assign w_new = small_sig1(win_r[14]) + win_r[9] + small_sig0(win_r[1]) + win_r[0];

  always_comb begin
    state_nxt    = state_r;
    after_nxt    = after_r;
    fill_nxt     = fill_r;
    rnd_nxt      = rnd_r;
    bitcnt_nxt   = bitcnt_r;
    sent80_nxt   = sent80_r;
    len_ok_nxt   = len_ok_r;
    out_busy_nxt = out_busy_r;
    out_idx_nxt  = out_idx_r;
    chain_nxt    = chain_r;
    vars_nxt     = vars_r;
    win_nxt      = win_r;
    dig_nxt      = dig_r;
    ins_en       = 1'b0;
    ins_byte     = pad_byte;

    if (out_acc) begin
      out_idx_nxt = out_idx_r + 3'd1;
      if (out_idx_r == 3'd7) begin
        out_busy_nxt = 1'b0;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            ins_en     = 1'b1;
            ins_byte   = in_tdata;
            bitcnt_nxt = bitcnt_r + 64'd8;
            if (fill_r == 6'd63) begin
              state_nxt = ST_ROUND;
              after_nxt = in_tlast ? AFT_PAD : AFT_IDLE;
            end else if (in_tlast) begin
              state_nxt = ST_PAD;
            end
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ins_en     = 1'b1;
        sent80_nxt = 1'b1;
        if (!sent80_r && fill_r < LEN_START) begin
          len_ok_nxt = 1'b1;
        end
        if (fill_r == 6'd63) begin
          state_nxt = ST_ROUND;
          // a block closed before the length fits spills into a second one
          after_nxt  = (sent80_r && len_ok_r) ? AFT_DONE : AFT_PAD;
          len_ok_nxt = 1'b1;
        end
      end
      ST_ROUND: begin
        vars_nxt[7] = vars_r[6];
        vars_nxt[6] = vars_r[5];
        vars_nxt[5] = vars_r[4];
        vars_nxt[4] = vars_r[3] + t1;
        vars_nxt[3] = vars_r[2];
        vars_nxt[2] = vars_r[1];
        vars_nxt[1] = vars_r[0];
        vars_nxt[0] = t1 + t2;
        for (int i = 0; i < WIN_WORDS - 1; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[WIN_WORDS - 1] = w_new;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + vars_r[i];
        end
        case (after_r)
          AFT_IDLE: state_nxt = ST_IDLE;
          AFT_PAD:  state_nxt = ST_PAD;
          AFT_DONE: state_nxt = ST_DONE;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_DONE: begin
        if (!out_busy_r) begin
          dig_nxt      = chain_r;
          out_busy_nxt = 1'b1;
          out_idx_nxt  = 3'd0;
          chain_nxt    = IV_TAB;
          bitcnt_nxt   = 64'd0;
          sent80_nxt   = 1'b0;
          len_ok_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // byte path: the window is a 512-bit shift line, first byte ends at the top of word 0
    if (ins_en) begin
      for (int i = 0; i < WIN_WORDS - 1; i++) begin
        win_nxt[i] = {win_r[i][23:0], win_r[i + 1][31:24]};
      end
      win_nxt[WIN_WORDS - 1] = {win_r[WIN_WORDS - 1][23:0], ins_byte};
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'd63) begin
        vars_nxt = chain_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      after_r    <= AFT_IDLE;
      fill_r     <= 6'd0;
      rnd_r      <= 6'd0;
      bitcnt_r   <= 64'd0;
      sent80_r   <= 1'b0;
      len_ok_r   <= 1'b0;
      out_busy_r <= 1'b0;
      out_idx_r  <= 3'd0;
      chain_r    <= IV_TAB;
    end else begin
      state_r    <= state_nxt;
      after_r    <= after_nxt;
      fill_r     <= fill_nxt;
      rnd_r      <= rnd_nxt;
      bitcnt_r   <= bitcnt_nxt;
      sent80_r   <= sent80_nxt;
      len_ok_r   <= len_ok_nxt;
      out_busy_r <= out_busy_nxt;
      out_idx_r  <= out_idx_nxt;
      chain_r    <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
    win_r  <= win_nxt;
    dig_r  <= dig_nxt;
  end

  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ROUND) |-> (rnd_r == 6'd0))
    else $error("round counter running outside the round state");

  a_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND || state_r == ST_ADD || state_r == ST_DONE) |-> (fill_r == 6'd0))
    else $error("block fill not empty during compression");

  a_done_from_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && $past(state_r) != ST_DONE) |-> ($past(state_r) == ST_ADD))
    else $error("digest hand-over not reached from the chain add");

  a_digest_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_busy_r) |=> (out_busy_r && out_idx_r == 3'd0))
    else $error("digest buffer not started at word zero");

endmodule
